// File: hw/rtl/ghst_pkg.sv
// shared types and constants for the generation handle slot table
package ghst_pkg;

  localparam int OPCODE_W = 2;
  localparam int HANDLE_W = 32;
  localparam int INDEX_W  = 24;
  localparam int GEN_W    = 8;
  localparam int SLOT_W   = 8;

  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: hw/rtl/ghst_in_if.sv
// request channel of the slot table
interface ghst_in_if import ghst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, output opcode, output handle_in, input ready);
  modport sink (input valid, input opcode, input handle_in, output ready);
endinterface

// File: hw/rtl/ghst_out_if.sv
// result channel of the slot table
interface ghst_out_if import ghst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] new_handle;
  logic                found;
  logic [SLOT_W-1:0]   slot_index;
  logic                table_full;

  modport source (output valid, output new_handle, output found, output slot_index,
                  output table_full, input ready);
  modport sink (input valid, input new_handle, input found, input slot_index,
                input table_full, output ready);
endinterface

// File: hw/rtl/ghst_ram.sv
// generic single-port-write ram with registered read
module ghst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/generation_handle_slot_table_unit.sv
// top level of the generation handle slot table
//
// Requests arrive on in_ch (opcode, handle_in) and each one yields exactly one
// result on out_ch (new_handle, found, slot_index, table_full); both channels
// move an item on valid and ready high at a rising edge.
// Allocate takes the lowest free slot, bumps its generation (255 wraps to 1)
// and returns {generation, slot+1}. Lookup checks a handle against the table.
// Clear frees every slot and keeps the generations.
// Slots are only freed all at once, so the busy slots always form a prefix and
// a fill count stands for the busy marks; generations live in one ram.
// An item first has its generation ram read registered at the accept edge;
// the execute state then computes, writes back and loads the output register,
// and holds while that register is still full. A new item is accepted only
// after the last has left execute. After reset a clearing pass writes zero to
// every generation entry, during which in_ch.ready stays low.
// When the receiver stalls, the result waits in the output register while the
// next item is accepted and read; that item then holds until the register frees.
module generation_handle_slot_table_unit import ghst_pkg::*; #(
  parameter int SLOT_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ghst_in_if.sink    in_ch,
  ghst_out_if.source out_ch
);

  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [ADDR_W-1:0]   wipe_r, wipe_nxt;

  logic [OPCODE_W-1:0] op_r;
  logic [ADDR_W-1:0]   slot_r;
  logic [GEN_W-1:0]    gen_r;
  logic                cand_r;

  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] new_handle_r, new_handle_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   slot_index_r, slot_index_nxt;
  logic                table_full_r, table_full_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [GEN_W-1:0]    ram_wdata, ram_rdata;

  logic                accept, exec_go, full;
  logic [INDEX_W-1:0]  raw_idx, req_slot;
  logic [GEN_W-1:0]    gen_inc, gen_new;
  logic                hit;

  ghst_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign exec_go     = !out_valid_r || out_ch.ready;
  assign full        = (fill_r == CNT_W'(SLOT_COUNT));

  assign raw_idx  = in_ch.handle_in[INDEX_W-1:0];
  assign req_slot = raw_idx - INDEX_W'(1);

  assign ram_re    = accept;
  assign ram_raddr = (in_ch.opcode == OP_ALLOC) ? fill_r[ADDR_W-1:0] : req_slot[ADDR_W-1:0];

  assign gen_inc = ram_rdata + GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign hit     = cand_r && (ram_rdata == gen_r);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    wipe_nxt       = wipe_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r[ADDR_W-1:0];
    ram_wdata      = gen_new;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    new_handle_nxt = new_handle_r;
    found_nxt      = found_r;
    slot_index_nxt = slot_index_r;
    table_full_nxt = table_full_r;
    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = wipe_r;
        ram_wdata = '0;
        wipe_nxt  = wipe_r + ADDR_W'(1);
        if (wipe_r == ADDR_W'(SLOT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          new_handle_nxt = '0;
          found_nxt      = 1'b0;
          slot_index_nxt = '0;
          table_full_nxt = 1'b0;
          case (op_r)
            OP_ALLOC: begin
              if (full) begin
                table_full_nxt = 1'b1;
              end else begin
                ram_we         = 1'b1;
                fill_nxt       = fill_r + CNT_W'(1);
                new_handle_nxt = {gen_new, INDEX_W'(fill_r) + INDEX_W'(1)};
                slot_index_nxt = SLOT_W'(fill_r);
              end
            end
            OP_LOOKUP: begin
              found_nxt = hit;
              if (hit) begin
                slot_index_nxt = SLOT_W'(slot_r);
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      fill_r      <= '0;
      wipe_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wipe_r      <= wipe_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.opcode;
      slot_r <= req_slot[ADDR_W-1:0];
      gen_r  <= in_ch.handle_in[HANDLE_W-1:INDEX_W];
      cand_r <= (raw_idx != '0) && (req_slot < INDEX_W'(fill_r));
    end
    new_handle_r <= new_handle_nxt;
    found_r      <= found_nxt;
    slot_index_r <= slot_index_nxt;
    table_full_r <= table_full_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_handle = new_handle_r;
  assign out_ch.found      = found_r;
  assign out_ch.slot_index = slot_index_r;
  assign out_ch.table_full = table_full_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(SLOT_COUNT))
    else $error("fill count beyond table size");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result loaded outside execute");

  a_full_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && table_full_r |-> full)
    else $error("full result while free slots remain");

  a_found_excl_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && table_full_r))
    else $error("hit and full on one result");

endmodule

// File: sim/generation_handle_slot_table_unit_tb.sv
// testbench for the generation handle slot table checked against a predictor
`timescale 1ns / 100ps

module generation_handle_slot_table_unit_tb import ghst_pkg::*;;

  localparam int SLOTS       = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_END [3] = '{900, 1400, 1850};

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [HANDLE_W-1:0] handle_in;
  } request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic                found;
    logic [SLOT_W-1:0]   slot_index;
    logic                table_full;
  } slot_result_t;

  logic clk;
  logic rst_n;

  ghst_in_if  in_ch ();
  ghst_out_if out_ch ();

  generation_handle_slot_table_unit #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic             slot_busy [SLOTS];
  logic [GEN_W-1:0] slot_gen  [SLOTS];

  request_t     pending_requests [$];
  slot_result_t awaited_results  [$];
  slot_result_t want;
  event         item_taken;
  bit           in_fired;
  int           in_idle_pct;
  int           out_idle_pct;
  int           n_sent;
  int           n_checked;
  int           n_hits;
  int           n_full;
  int           n_mismatches;
  int           cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [HANDLE_W-1:0] make_ref(input int unsigned slot,
                                                   input logic [GEN_W-1:0] gen);
    return {gen, INDEX_W'(slot + 1)};
  endfunction

  // advances the slot table by one request and returns what it should answer
  function automatic slot_result_t apply_request(input request_t r);
    slot_result_t     res;
    logic [GEN_W-1:0] g;
    logic [INDEX_W-1:0] raw;
    int               slot;
    res = '0;
    case (r.opcode)
      OP_ALLOC: begin
        res.table_full = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i]) begin
            g = slot_gen[i] + 8'd1;
            if (g == '0) g = 8'd1;
            slot_busy[i]   = 1'b1;
            slot_gen[i]    = g;
            res.new_handle = make_ref(i, g);
            res.slot_index = SLOT_W'(i);
            res.table_full = 1'b0;
            break;
          end
        end
      end
      OP_LOOKUP: begin
        raw = r.handle_in[INDEX_W-1:0];
        if (r.handle_in != '0 && raw != '0) begin
          slot = int'(raw) - 1;
          if (slot < SLOTS && slot_busy[slot] &&
              slot_gen[slot] == r.handle_in[HANDLE_W-1:INDEX_W]) begin
            res.found      = 1'b1;
            res.slot_index = SLOT_W'(slot);
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_busy_slot();
    int start;
    start = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[(start + i) % SLOTS]) return (start + i) % SLOTS;
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch: %s at result %0d: got %0h, expected %0h", what, n_checked, got,
             exp_val);
    n_mismatches++;
  endtask

  task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [HANDLE_W-1:0] h);
    request_t r;
    r.opcode    = op;
    r.handle_in = h;
    pending_requests.push_back(r);
    n_sent++;
  endtask

  task automatic wait_taken();
    while (pending_requests.size() != 0) @(item_taken);
  endtask

  task automatic drain_all();
    wait_taken();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // driver: accept side at the rising edge, new item at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      awaited_results.push_back(apply_request(pending_requests.pop_front()));
      in_fired = 1'b1;
      -> item_taken;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_fired) begin
        in_fired = 1'b0;
        if (pending_requests.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.opcode    <= pending_requests[0].opcode;
          in_ch.handle_in <= pending_requests[0].handle_in;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.new_handle, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.new_handle !== want.new_handle)
          report_mismatch("new_handle", out_ch.new_handle, want.new_handle);
        if (out_ch.found !== want.found)
          report_mismatch("found", 32'(out_ch.found), 32'(want.found));
        if (out_ch.slot_index !== want.slot_index)
          report_mismatch("slot_index", 32'(out_ch.slot_index), 32'(want.slot_index));
        if (out_ch.table_full !== want.table_full)
          report_mismatch("table_full", 32'(out_ch.table_full), 32'(want.table_full));
        n_checked++;
        if (want.found) n_hits++;
        if (want.table_full) n_full++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("** generation_handle_slot_table_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int free_slots;
    int s;
    int kind;
    int n;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_ALLOC;
    in_ch.handle_in = '0;
    out_ch.ready    = 1'b0;
    in_fired        = 1'b0;
    in_idle_pct     = 9;
    out_idle_pct    = 63;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_gen[i]  = '0;
    end

    // lookups on an empty table, then a small alloc, lookup and clear walk
    push_item(OP_LOOKUP, '0);
    push_item(OP_LOOKUP, 32'hFF00_0000);
    push_item(OP_LOOKUP, make_ref(SLOTS, 8'h01));
    push_item(OP_LOOKUP, 32'h5AFF_FFFF);
    push_item(OP_ALLOC, 32'hFFFF_FFFF);
    push_item(OP_ALLOC, '0);
    push_item(OP_LOOKUP, make_ref(0, 8'h01));
    push_item(OP_LOOKUP, make_ref(1, 8'h01));
    push_item(OP_LOOKUP, make_ref(0, 8'h02));
    push_item(OP_LOOKUP, make_ref(0, 8'h00));
    push_item(OP_LOOKUP, make_ref(2, 8'h00));
    push_item(OP_LOOKUP, make_ref(SLOTS - 1, 8'h00));
    push_item(OP_UNUSED, 32'hFFFF_FFFF);
    push_item(OP_UNUSED, make_ref(0, 8'h01));
    push_item(OP_CLEAR, 32'hA5A5_A5A5);
    push_item(OP_LOOKUP, make_ref(0, 8'h01));
    push_item(OP_ALLOC, '0);
    push_item(OP_LOOKUP, make_ref(0, 8'h02));
    push_item(OP_LOOKUP, make_ref(0, 8'h01));
    push_item(OP_ALLOC, '0);
    push_item(OP_CLEAR, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      drain_all();
      case (ph)
        0: begin
          in_idle_pct  = 9;
          out_idle_pct = 63;
        end
        1: begin
          in_idle_pct  = 63;
          out_idle_pct = 9;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // reuse slot zero until its generation wraps past 255
        push_item(OP_CLEAR, $urandom);
        for (int k = 0; k < 260; k++) begin
          push_item(OP_ALLOC, $urandom);
          wait_taken();
          push_item(OP_LOOKUP, make_ref(0, slot_gen[0]));
          if ($urandom_range(3) == 0)
            push_item(OP_LOOKUP, make_ref(0, slot_gen[0] + 8'($urandom_range(255, 1))));
          push_item(OP_CLEAR, $urandom);
        end
      end else begin
        // fill the table and run past full
        wait_taken();
        free_slots = 0;
        for (int i = 0; i < SLOTS; i++) if (!slot_busy[i]) free_slots++;
        n = free_slots + $urandom_range(3, 1);
        for (int k = 0; k < n; k++) push_item(OP_ALLOC, $urandom);
        wait_taken();
        push_item(OP_LOOKUP, make_ref(SLOTS - 1, slot_gen[SLOTS - 1]));
        for (int k = 0; k < 4; k++) begin
          s = pick_busy_slot();
          push_item(OP_LOOKUP, make_ref(s, slot_gen[s]));
        end
      end

      while (n_sent < PHASE_END[ph]) begin
        wait_taken();
        kind = $urandom_range(99);
        if (kind < 35) begin
          n = $urandom_range(6, 1);
          for (int k = 0; k < n; k++) push_item(OP_ALLOC, $urandom);
        end else if (kind < 60) begin
          n = $urandom_range(4, 1);
          for (int k = 0; k < n; k++) begin
            s = pick_busy_slot();
            if (s < 0) push_item(OP_LOOKUP, $urandom);
            else push_item(OP_LOOKUP, make_ref(s, slot_gen[s]));
          end
        end else if (kind < 80) begin
          n = $urandom_range(4, 1);
          for (int k = 0; k < n; k++) begin
            s = $urandom_range(SLOTS - 1);
            case ($urandom_range(3))
              0: push_item(OP_LOOKUP,
                           make_ref(s, slot_gen[s] + 8'($urandom_range(255, 1))));
              1: push_item(OP_LOOKUP, make_ref(s, slot_gen[s]));
              2: push_item(OP_LOOKUP,
                           make_ref($urandom_range(24'hFFFFFE, SLOTS), 8'($urandom)));
              default: push_item(OP_LOOKUP, {8'($urandom), 24'h0});
            endcase
          end
        end else if (kind < 93) begin
          push_item(2'($urandom), $urandom);
        end else begin
          push_item(OP_CLEAR, $urandom);
        end
      end
    end

    drain_all();
    repeat (SETTLE) @(posedge clk);
    $display("%0d requests driven across three idle patterns, %0d results checked", n_sent,
             n_checked);
    $display("%0d lookup hits, %0d allocations refused on a full table", n_hits, n_full);
    if (n_mismatches == 0) begin
      $display("** generation_handle_slot_table_unit: PASSED **");
    end else begin
      $display("** generation_handle_slot_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
